@@ hdl/pwcg_pkg.sv @@
// Package for the perspective warp coordinate generator.
// Holds the request payload types and the configuration register indexes.
// Depends on nothing.
`timescale 1ns / 1ps

package pwcg_pkg;

  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgM0M1   = 3'd0,
    CfgM2M3   = 3'd1,
    CfgM4M5   = 3'd2,
    CfgM6M7   = 3'd3,
    CfgM8     = 3'd4,
    CfgMode   = 3'd5,
    CfgOrigX  = 3'd6,
    CfgOrigY  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [10:0] dest_x;
    logic [10:0] dest_y;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] src_x;
    logic signed [15:0] src_y;
    logic [9:0]         frac_index;
    logic               degenerate;
  } out_req_t;

endpackage

@@ hdl/perspective_warp_coord_gen_top.sv @@
// Perspective warp coordinate generator: homography, pipelined divide, rounding.
// Depends on pwcg_pkg.
`timescale 1ns / 1ps

// Usage:
// Destination pixels arrive as requests on the in channel (valid/ready) and
// each gives exactly one source coordinate request on the out channel.
// The configuration port writes the inverse homography, the interpolation
// mode and the origin; the user writes it only while no request is in
// flight, as the block itself does not enforce this.
// A request passes the offset, multiply, sum and magnitude preparation
// registers, the 34-stage pipelined restoring divider, a rounding register
// and a clamping/output register.
// Throughput is one request per cycle unless the receiver stalls.
// When the receiver stalls, the whole pipeline holds and in_ready_o falls,
// so nothing is lost or repeated.
// Reset empties the pipeline and loads the identity matrix, bilinear mode
// and a zero origin.
module perspective_warp_coord_gen_top #(
  parameter int unsigned MAX_DIM   = 2048,
  parameter int unsigned FRAC_BITS = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [2:0]                cfg_idx_i,
  input  logic [63:0]               cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  pwcg_pkg::in_req_t         in_req_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output pwcg_pkg::out_req_t        out_req_o
);
  import pwcg_pkg::*;

  localparam int unsigned UW = 17;
  localparam int unsigned PW = 49;
  localparam int unsigned SW = 49;
  localparam int unsigned DW = 48;
  localparam int unsigned RW = DW + 1;
  localparam int unsigned NW = DW + FRAC_BITS;
  localparam int unsigned QB = 34;
  localparam int unsigned FW = 2 * FRAC_BITS;
  localparam logic [10:0] DMAX = 11'(MAX_DIM - 1);

  typedef struct packed {
    logic          vld;
    logic          mode;
    logic          degen;
    logic          negx;
    logic          negy;
    logic          ovfx;
    logic          ovfy;
    logic [NW-1:0] nx;
    logic [NW-1:0] ny;
    logic [DW-1:0] d;
    logic [RW-1:0] rx;
    logic [RW-1:0] ry;
    logic [QB-1:0] qx;
    logic [QB-1:0] qy;
  } div_t;

  typedef struct packed {
    logic          vld;
    logic          mode;
    logic          degen;
    logic          negx;
    logic          negy;
    logic          ovfx;
    logic          ovfy;
    logic [QB:0]   qx;
    logic [QB:0]   qy;
  } rnd_t;

  logic [63:0]        m01_q, m23_q, m45_q, m67_q;
  logic signed [31:0] m8_q;
  logic               mode_q;
  logic signed [15:0] ox_q, oy_q;

  logic signed [31:0] m0, m1, m2, m3, m4, m5, m6, m7;
  logic               en;

  logic                 s1_vld_q;
  logic signed [UW-1:0] u_q, v_q;
  logic [10:0]          dxc, dyc;

  logic                 s2_vld_q;
  logic signed [PW-1:0] p0_q, p1_q, p3_q, p4_q, p6_q, p7_q;

  logic                 s3_vld_q;
  logic signed [SW-1:0] x_q, y_q, w_q;

  div_t div_q [QB+1];
  div_t prep_d;
  rnd_t rnd_q;

  logic [DW-1:0] magx, magy, magw;

  logic               out_vld_q;
  out_req_t           out_q;
  logic signed [31:0] qvx, qvy, sx, sy;
  logic [FW-1:0]      fcat;
  logic [19:0]        fwide;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m01_q  <= 64'd4503599627370496;
      m23_q  <= '0;
      m45_q  <= 64'd4503599627370496;
      m67_q  <= '0;
      m8_q   <= 32'sd1048576;
      mode_q <= 1'b1;
      ox_q   <= '0;
      oy_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgM0M1:  m01_q  <= cfg_wdata_i;
        CfgM2M3:  m23_q  <= cfg_wdata_i;
        CfgM4M5:  m45_q  <= cfg_wdata_i;
        CfgM6M7:  m67_q  <= cfg_wdata_i;
        CfgM8:    m8_q   <= cfg_wdata_i[31:0];
        CfgMode:  mode_q <= cfg_wdata_i[0];
        CfgOrigX: ox_q   <= cfg_wdata_i[15:0];
        CfgOrigY: oy_q   <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign m0 = m01_q[63:32];
  assign m1 = m01_q[31:0];
  assign m2 = m23_q[63:32];
  assign m3 = m23_q[31:0];
  assign m4 = m45_q[63:32];
  assign m5 = m45_q[31:0];
  assign m6 = m67_q[63:32];
  assign m7 = m67_q[31:0];

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  assign dxc = (in_req_i.dest_x > DMAX) ? DMAX : in_req_i.dest_x;
  assign dyc = (in_req_i.dest_y > DMAX) ? DMAX : in_req_i.dest_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q  <= $signed({6'b0, dxc}) - UW'(ox_q);
      v_q  <= $signed({6'b0, dyc}) - UW'(oy_q);
      p0_q <= PW'(m0) * PW'(u_q);
      p1_q <= PW'(m1) * PW'(v_q);
      p3_q <= PW'(m3) * PW'(u_q);
      p4_q <= PW'(m4) * PW'(v_q);
      p6_q <= PW'(m6) * PW'(u_q);
      p7_q <= PW'(m7) * PW'(v_q);
      x_q  <= p0_q + p1_q + SW'(m2);
      y_q  <= p3_q + p4_q + SW'(m5);
      w_q  <= p6_q + p7_q + SW'(m8_q);
    end
  end

  assign magx = DW'(x_q[SW-1] ? -x_q : x_q);
  assign magy = DW'(y_q[SW-1] ? -y_q : y_q);
  assign magw = DW'(w_q[SW-1] ? -w_q : w_q);

  always_comb begin
    prep_d       = '0;
    prep_d.vld   = s3_vld_q;
    prep_d.mode  = mode_q;
    prep_d.degen = (w_q == '0);
    prep_d.negx  = x_q[SW-1] ^ w_q[SW-1];
    prep_d.negy  = y_q[SW-1] ^ w_q[SW-1];
    prep_d.nx    = mode_q ? (NW'(magx) << FRAC_BITS) : NW'(magx);
    prep_d.ny    = mode_q ? (NW'(magy) << FRAC_BITS) : NW'(magy);
    prep_d.d     = magw;
    prep_d.rx    = RW'(prep_d.nx >> QB);
    prep_d.ry    = RW'(prep_d.ny >> QB);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q[0] <= '0;
    end else if (en) begin
      div_q[0] <= prep_d;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    div_t          nxt;
    logic [RW-1:0] sx_r, sy_r;
    logic          bx, by;

    always_comb begin
      nxt  = div_q[k];
      sx_r = {div_q[k].rx[RW-2:0], div_q[k].nx[QB-1-k]};
      sy_r = {div_q[k].ry[RW-2:0], div_q[k].ny[QB-1-k]};
      bx   = (sx_r >= {1'b0, div_q[k].d});
      by   = (sy_r >= {1'b0, div_q[k].d});
      nxt.rx = bx ? (sx_r - {1'b0, div_q[k].d}) : sx_r;
      nxt.ry = by ? (sy_r - {1'b0, div_q[k].d}) : sy_r;
      nxt.qx = {div_q[k].qx[QB-2:0], bx};
      nxt.qy = {div_q[k].qy[QB-2:0], by};
      if (k == 0) begin
        nxt.ovfx = (div_q[k].rx >= {1'b0, div_q[k].d});
        nxt.ovfy = (div_q[k].ry >= {1'b0, div_q[k].d});
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_q[k+1] <= '0;
      end else if (en) begin
        div_q[k+1] <= nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q <= '0;
    end else if (en) begin
      rnd_q.vld   <= div_q[QB].vld;
      rnd_q.mode  <= div_q[QB].mode;
      rnd_q.degen <= div_q[QB].degen;
      rnd_q.negx  <= div_q[QB].negx;
      rnd_q.negy  <= div_q[QB].negy;
      rnd_q.ovfx  <= div_q[QB].ovfx;
      rnd_q.ovfy  <= div_q[QB].ovfy;
      rnd_q.qx    <= (QB+1)'(div_q[QB].qx) + (QB+1)'(
                     {div_q[QB].rx[RW-2:0], 1'b0} >= {1'b0, div_q[QB].d});
      rnd_q.qy    <= (QB+1)'(div_q[QB].qy) + (QB+1)'(
                     {div_q[QB].ry[RW-2:0], 1'b0} >= {1'b0, div_q[QB].d});
    end
  end

  always_comb begin
    if (rnd_q.degen) begin
      qvx = '0;
    end else if (rnd_q.negx) begin
      if (rnd_q.ovfx || rnd_q.qx > (QB+1)'(33'h080000000)) begin
        qvx = 32'sh80000000;
      end else begin
        qvx = -$signed(rnd_q.qx[31:0]);
      end
    end else begin
      if (rnd_q.ovfx || rnd_q.qx > (QB+1)'(32'h7fffffff)) begin
        qvx = 32'sh7fffffff;
      end else begin
        qvx = $signed(rnd_q.qx[31:0]);
      end
    end
    if (rnd_q.degen) begin
      qvy = '0;
    end else if (rnd_q.negy) begin
      if (rnd_q.ovfy || rnd_q.qy > (QB+1)'(33'h080000000)) begin
        qvy = 32'sh80000000;
      end else begin
        qvy = -$signed(rnd_q.qy[31:0]);
      end
    end else begin
      if (rnd_q.ovfy || rnd_q.qy > (QB+1)'(32'h7fffffff)) begin
        qvy = 32'sh7fffffff;
      end else begin
        qvy = $signed(rnd_q.qy[31:0]);
      end
    end
    sx    = rnd_q.mode ? (qvx >>> FRAC_BITS) : qvx;
    sy    = rnd_q.mode ? (qvy >>> FRAC_BITS) : qvy;
    fcat  = {qvy[FRAC_BITS-1:0], qvx[FRAC_BITS-1:0]};
    fwide = 20'(fcat);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= rnd_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.src_x      <= sx[15:0] + ox_q;
      out_q.src_y      <= sy[15:0] + oy_q;
      out_q.frac_index <= rnd_q.mode ? fwide[9:0] : 10'd0;
      out_q.degenerate <= rnd_q.degen;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_req_o   = out_q;

endmodule
